### sv/pmp_pkg.sv
// pmp_pkg: shared types, character codes and the field scanner step for the
// pointer message parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmp_pkg;

   // message field phase, one-hot
   typedef enum logic [3:0] {
      PH_X    = 4'b0001,
      PH_Y    = 4'b0010,
      PH_CMD  = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   // number scanner mode, one-hot
   typedef enum logic [2:0] {
      SC_SKIP   = 3'b001,
      SC_DIGITS = 3'b010,
      SC_DONE   = 3'b100
   } scan_type;

   typedef struct packed {
      logic [15:0] acc;
      scan_type    mode;
      logic        neg;
   } scan_state_type;

   // separator, sign, digit and whitespace characters
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // command characters
   localparam logic [7:0] CMD_RIGHT_CLICK = 8'h72; // 'r'
   localparam logic [7:0] CMD_LEFT_CLICK  = 8'h73; // 's'
   localparam logic [7:0] CMD_LEFT_PRESS  = 8'h68; // 'h'
   localparam logic [7:0] CMD_KEY_D8      = 8'h69; // 'i'
   localparam logic [7:0] CMD_KEY_D7      = 8'h74; // 't'

   // action codes
   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_RIGHT_CLICK = 3'd1;
   localparam logic [2:0] ACT_LEFT_CLICK  = 3'd2;
   localparam logic [2:0] ACT_LEFT_PRESS  = 3'd3;
   localparam logic [2:0] ACT_KEY_D8      = 3'd4;
   localparam logic [2:0] ACT_KEY_D7      = 3'd5;

   localparam int RSP_DATA_W = 48;

   // one character through a whitespace / sign / digits scanner
   function automatic scan_state_type scan_step(input scan_state_type cur,
                                                input logic [7:0] ch);
      scan_state_type nxt;
      logic           digit;
      logic           space;
      logic           in_digits;
      nxt       = cur;
      digit     = ch inside {[CH_ZERO:CH_NINE]};
      space     = ch inside {CH_SPACE, [CH_TAB:CH_CR]};
      in_digits = 1'b0;
      case (cur.mode)
         SC_SKIP: begin
            if (space) begin
               nxt.mode = SC_SKIP;
            end else if (ch == CH_MINUS) begin
               nxt.neg  = 1'b1;
               nxt.mode = SC_DIGITS;
            end else if (ch == CH_PLUS) begin
               nxt.mode = SC_DIGITS;
            end else begin
               in_digits = 1'b1;
            end
         end
         SC_DIGITS: begin
            in_digits = 1'b1;
         end
         default: begin
            nxt.mode = SC_DONE;
         end
      endcase
      // accumulate acc * 10 + digit, wrapping at 16 bits
      if (in_digits) begin
         if (digit) begin
            nxt.acc  = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0}
                       + {12'd0, ch[3:0]};
            nxt.mode = SC_DIGITS;
         end else begin
            nxt.mode = SC_DONE;
         end
      end
      return nxt;
   endfunction

   // command character to action code
   function automatic logic [2:0] action_of(input logic [7:0] cmd);
      logic [2:0] act;
      case (cmd)
         CMD_RIGHT_CLICK: act = ACT_RIGHT_CLICK;
         CMD_LEFT_CLICK:  act = ACT_LEFT_CLICK;
         CMD_LEFT_PRESS:  act = ACT_LEFT_PRESS;
         CMD_KEY_D8:      act = ACT_KEY_D8;
         CMD_KEY_D7:      act = ACT_KEY_D7;
         default:         act = ACT_NONE;
      endcase
      return act;
   endfunction

   // apply the sign to a magnitude
   function automatic logic [15:0] signed_value(input logic [15:0] acc,
                                                input logic neg);
      return neg ? (~acc + 16'd1) : acc;
   endfunction

endpackage

`default_nettype wire

### sv/pointer_message_parser.sv
// Pointer message parser: decodes a byte stream "<X>H<Y>A<cmd>" into one
// movement and action result per message. Depends on pmp_pkg.
//
// One message byte is taken per clock on the req_ stream; req_tlast marks the
// last byte of a message. The byte is folded into the field scanners in the
// same cycle, so a new byte can be taken every cycle. On the last byte the
// result is loaded into the rsp_ output register and appears in the next cycle;
// req_tready stays high while that register is empty or being drained, so the
// only stall is a result still held by the consumer. X and Y wrap at 16 bits,
// bytes past MAX_MSG_LEN in a message are dropped (their tlast still closes
// the message), and the action is nonzero only when the command character
// changes from the previous message.
`timescale 1ns / 1ps
`default_nettype none

module pointer_message_parser #(
   parameter int MAX_MSG_LEN = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // [7:0] msg_byte
   input  wire logic                             req_tlast,  // last_byte
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] x_value, [31:16] y_value, [34:32] action, [42:35] command_char,
   // [47:43] zero
   output logic [pmp_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int POS_W = $clog2(MAX_MSG_LEN + 1);

   // message state
   pmp_pkg::phase_type      phase_ff, phase_in;
   pmp_pkg::scan_state_type x_scan_ff, x_scan_in;
   pmp_pkg::scan_state_type y_scan_ff, y_scan_in;
   logic [7:0]              held_cmd_ff, held_cmd_in;
   logic [7:0]              prev_cmd_ff, prev_cmd_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_x_ff, rsp_x_in;
   logic [15:0]             rsp_y_ff, rsp_y_in;
   logic [2:0]              rsp_act_ff, rsp_act_in;
   logic [7:0]              rsp_cmd_ff, rsp_cmd_in;

   logic                    req_acc;
   logic [7:0]              ch;
   pmp_pkg::phase_type      step_phase;
   pmp_pkg::scan_state_type x_step, y_step;
   logic [7:0]              step_cmd;
   logic [7:0]              final_cmd;

   localparam pmp_pkg::scan_state_type SCAN_CLEAR = '{
      acc:  16'd0,
      mode: pmp_pkg::SC_SKIP,
      neg:  1'b0
   };

   // handshake: accept while the output slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign ch         = req_tdata;

   // per-byte field update
   always_comb begin
      step_phase = phase_ff;
      x_step     = x_scan_ff;
      y_step     = y_scan_ff;
      step_cmd   = held_cmd_ff;
      if (pos_ff < POS_W'(MAX_MSG_LEN)) begin
         case (phase_ff)
            pmp_pkg::PH_X: begin
               if (ch == pmp_pkg::CH_H) begin
                  x_step.mode = pmp_pkg::SC_DONE;
                  step_phase  = pmp_pkg::PH_Y;
               end else if (ch == pmp_pkg::CH_A) begin
                  x_step.mode = pmp_pkg::SC_DONE;
                  y_step.mode = pmp_pkg::SC_DONE;
                  step_phase  = pmp_pkg::PH_CMD;
               end else begin
                  x_step = pmp_pkg::scan_step(x_scan_ff, ch);
               end
            end
            pmp_pkg::PH_Y: begin
               if (ch == pmp_pkg::CH_A) begin
                  y_step.mode = pmp_pkg::SC_DONE;
                  step_phase  = pmp_pkg::PH_CMD;
               end else begin
                  y_step = pmp_pkg::scan_step(y_scan_ff, ch);
               end
            end
            pmp_pkg::PH_CMD: begin
               step_cmd   = ch;
               step_phase = pmp_pkg::PH_DONE;
            end
            default: begin
               step_phase = phase_ff;
            end
         endcase
      end
   end

   // an 'A' with nothing after it clears the command
   assign final_cmd = (step_phase == pmp_pkg::PH_CMD) ? 8'd0 : step_cmd;

   // next state and result load
   always_comb begin
      phase_in     = phase_ff;
      x_scan_in    = x_scan_ff;
      y_scan_in    = y_scan_ff;
      held_cmd_in  = held_cmd_ff;
      prev_cmd_in  = prev_cmd_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      if (req_acc) begin
         if (req_tlast) begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = pmp_pkg::signed_value(x_step.acc, x_step.neg);
            rsp_y_in     = pmp_pkg::signed_value(y_step.acc, y_step.neg);
            rsp_act_in   = (final_cmd != prev_cmd_ff) ?
                           pmp_pkg::action_of(final_cmd) : pmp_pkg::ACT_NONE;
            rsp_cmd_in   = final_cmd;
            held_cmd_in  = final_cmd;
            prev_cmd_in  = final_cmd;
            phase_in     = pmp_pkg::PH_X;
            x_scan_in    = SCAN_CLEAR;
            y_scan_in    = SCAN_CLEAR;
            pos_in       = '0;
         end else begin
            phase_in    = step_phase;
            x_scan_in   = x_step;
            y_scan_in   = y_step;
            held_cmd_in = step_cmd;
            if (pos_ff < POS_W'(MAX_MSG_LEN)) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   // control and scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pmp_pkg::PH_X;
         x_scan_ff    <= SCAN_CLEAR;
         y_scan_ff    <= SCAN_CLEAR;
         held_cmd_ff  <= 8'd0;
         prev_cmd_ff  <= 8'd0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         x_scan_ff    <= x_scan_in;
         y_scan_ff    <= y_scan_in;
         held_cmd_ff  <= held_cmd_in;
         prev_cmd_ff  <= prev_cmd_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_act_ff <= rsp_act_in;
      rsp_cmd_ff <= rsp_cmd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_cmd_ff, rsp_act_ff, rsp_y_ff, rsp_x_ff};

   // checks
   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> rsp_valid_ff)
      else $error("last byte did not load a result");

   a_last_clears_msg: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> pos_ff == '0 && phase_ff == pmp_pkg::PH_X)
      else $error("message state not cleared after last byte");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_MSG_LEN))
      else $error("byte position beyond maximum length");

   a_prev_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> prev_cmd_ff == rsp_cmd_ff)
      else $error("previous command differs from pending result command");

   a_action_on_change: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast && final_cmd == prev_cmd_ff
      |=> rsp_act_ff == pmp_pkg::ACT_NONE)
      else $error("action raised without command change");

endmodule

`default_nettype wire
